// ----- sv/pol_pkg.sv -----
// pol_pkg: shared types and constants for the positional ordered list
// command kinds, position selectors, status codes and the queued command beat
package pol_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned VW = 32;
  localparam int unsigned PW = 5;
  localparam int unsigned MW = 3;
  localparam int unsigned SW = 2;

  localparam logic [MW-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [MW-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [MW-1:0] MODE_INS_POS   = 3'd2;
  localparam logic [MW-1:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [MW-1:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [MW-1:0] MODE_DEL_POS   = 3'd5;
  localparam logic [MW-1:0] MODE_READ      = 3'd6;

  localparam logic [SW-1:0] STAT_OK     = 2'd0;
  localparam logic [SW-1:0] STAT_BADPOS = 2'd1;
  localparam logic [SW-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [SW-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [1:0] {
    K_INSERT,
    K_DELETE,
    K_READ,
    K_NOP
  } kind_e;

  typedef enum logic [1:0] {
    SEL_FRONT,
    SEL_BACK,
    SEL_POS
  } sel_e;

  typedef struct packed {
    kind_e                kind;
    sel_e                 sel;
    logic signed [VW-1:0] value;
    logic [PW-1:0]        position;
  } pol_cmd_t;

endpackage

// ----- sv/pol_front.sv -----
// pol_front: accepts command beats and classifies the mode into kind and selector
// depends on pol_pkg
module pol_front import pol_pkg::*; (
  input  logic                 start_i,
  input  logic                 full_i,
  input  logic [MW-1:0]        mode_i,
  input  logic signed [VW-1:0] value_i,
  input  logic [PW-1:0]        position_i,
  output logic                 push_o,
  output pol_cmd_t             cmd_o
);

  assign push_o = start_i && !full_i;

  always_comb begin
    cmd_o.value    = value_i;
    cmd_o.position = position_i;
    unique case (mode_i)
      MODE_INS_FRONT: begin cmd_o.kind = K_INSERT; cmd_o.sel = SEL_FRONT; end
      MODE_INS_BACK:  begin cmd_o.kind = K_INSERT; cmd_o.sel = SEL_BACK;  end
      MODE_INS_POS:   begin cmd_o.kind = K_INSERT; cmd_o.sel = SEL_POS;   end
      MODE_DEL_FRONT: begin cmd_o.kind = K_DELETE; cmd_o.sel = SEL_FRONT; end
      MODE_DEL_BACK:  begin cmd_o.kind = K_DELETE; cmd_o.sel = SEL_BACK;  end
      MODE_DEL_POS:   begin cmd_o.kind = K_DELETE; cmd_o.sel = SEL_POS;   end
      MODE_READ:      begin cmd_o.kind = K_READ;   cmd_o.sel = SEL_FRONT; end
      default:        begin cmd_o.kind = K_NOP;    cmd_o.sel = SEL_FRONT; end
    endcase
  end

endmodule

// ----- sv/pol_queue.sv -----
// pol_queue: short command queue between front and back
// depends on pol_pkg
module pol_queue import pol_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pol_cmd_t cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output pol_cmd_t cmd_o
);

  localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(QDEPTH + 1);

  pol_cmd_t        mem_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/pol_back.sv -----
// pol_back: executes queued commands on the shift-register list and drives results
// depends on pol_pkg
module pol_back import pol_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  pol_cmd_t             cmd_i,
  output logic                 pop_o,
  output logic                 valid_o,
  output logic [SW-1:0]        status_o,
  output logic signed [VW-1:0] entry_value_o,
  output logic [CW-1:0]        entry_count_o,
  output logic                 last_o
);

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = ((CW > PW) ? CW : PW) + 1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e               state_q;
  logic signed [VW-1:0] store_q [CAPACITY];
  logic [CW-1:0]        count_q;
  logic [IW-1:0]        rd_idx_q;
  logic                 valid_q, last_q;
  logic [SW-1:0]        status_q;
  logic signed [VW-1:0] value_q;
  logic [CW-1:0]        res_count_q;

  logic [CMPW-1:0] cnt_ext, pos_ext, ins_idx, del_idx;
  logic            is_full, is_empty, do_ins, do_del, do_read;
  logic [SW-1:0]   op_status;

  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign cnt_ext  = CMPW'(count_q);
  assign pos_ext  = CMPW'(cmd_i.position);
  assign is_full  = (cnt_ext >= CMPW'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    op_status = STAT_OK;
    do_ins    = 1'b0;
    do_del    = 1'b0;
    do_read   = 1'b0;
    case (cmd_i.sel)
      SEL_BACK: begin
        ins_idx = cnt_ext;
        del_idx = cnt_ext - 1'b1;
      end
      SEL_POS: begin
        ins_idx = pos_ext - 1'b1;
        del_idx = pos_ext - 1'b1;
      end
      default: begin
        ins_idx = '0;
        del_idx = '0;
      end
    endcase
    unique case (cmd_i.kind)
      K_INSERT: begin
        if (cmd_i.sel == SEL_POS && (pos_ext == '0 || pos_ext > cnt_ext + 1'b1)) begin
          op_status = STAT_BADPOS;
        end else if (is_full) begin
          op_status = STAT_FULL;
        end else begin
          do_ins = pop_o;
        end
      end
      K_DELETE: begin
        if (is_empty) begin
          op_status = STAT_EMPTY;
        end else if (cmd_i.sel == SEL_POS && (pos_ext == '0 || pos_ext > cnt_ext)) begin
          op_status = STAT_BADPOS;
        end else begin
          do_del = pop_o;
        end
      end
      K_READ: begin
        if (is_empty) begin
          op_status = STAT_EMPTY;
        end else begin
          do_read = pop_o;
        end
      end
      default: op_status = STAT_OK;
    endcase
  end

  // entries shift in parallel, each cell looks at its neighbors only
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (do_ins) begin
        if (CMPW'(i) == ins_idx) begin
          store_q[i] <= cmd_i.value;
        end else if (i > 0 && CMPW'(i) > ins_idx && CMPW'(i) <= cnt_ext) begin
          store_q[i] <= store_q[(i > 0) ? i - 1 : 0];
        end
      end else if (do_del) begin
        if (i < CAPACITY - 1 && CMPW'(i) >= del_idx && CMPW'(i) + 1'b1 < cnt_ext) begin
          store_q[i] <= store_q[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_idx_q    <= '0;
      valid_q     <= 1'b0;
      last_q      <= 1'b0;
      status_q    <= STAT_OK;
      value_q     <= '0;
      res_count_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            valid_q  <= 1'b1;
            status_q <= op_status;
            value_q  <= '0;
            last_q   <= 1'b1;
            if (do_ins) begin
              count_q     <= count_q + 1'b1;
              res_count_q <= count_q + 1'b1;
            end else if (do_del) begin
              count_q     <= count_q - 1'b1;
              res_count_q <= count_q - 1'b1;
            end else begin
              res_count_q <= count_q;
            end
            if (do_read) begin
              value_q  <= store_q[0];
              last_q   <= (count_q == CW'(1));
              rd_idx_q <= IW'(1);
              if (count_q != CW'(1)) begin
                state_q <= ST_READ;
              end
            end
          end
        end
        ST_READ: begin
          valid_q     <= 1'b1;
          status_q    <= STAT_OK;
          value_q     <= store_q[rd_idx_q];
          res_count_q <= count_q;
          last_q      <= (CW'(rd_idx_q) + 1'b1 == count_q);
          rd_idx_q    <= rd_idx_q + 1'b1;
          if (CW'(rd_idx_q) + 1'b1 == count_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign entry_value_o = value_q;
  assign entry_count_o = res_count_q;
  assign last_o        = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_read_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> valid_q && !last_q)
    else $error("readout gap or early last");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !q_empty_i)
    else $error("pop from empty queue");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && status_q == STAT_FULL |-> res_count_q == CW'(CAPACITY))
    else $error("full status with room left");

  a_ins_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ins |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the list");

endmodule

// ----- sv/positional_ordered_list_top.sv -----
// positional_ordered_list_top: bounded ordered list with positional insert and delete
// depends on pol_pkg, pol_front, pol_queue, pol_back
//
// A command beat is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Each insert, delete or no-op command gives
// one result in the cycle after it leaves the queue, so commands sustain one per cycle
// outside a readout. A readout gives one result per stored entry, one per cycle, front
// first, with last_o on the final one (a single empty-status result for an empty list);
// the queue is not drained during a readout. Results show on valid_o for one cycle and
// cannot be stalled. There is no clearing pass: the list is empty right after reset.
module positional_ordered_list_top import pol_pkg::*; #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [MW-1:0]        mode_i,
  input  logic signed [VW-1:0] value_i,
  input  logic [PW-1:0]        position_i,
  output logic                 valid_o,
  output logic [SW-1:0]        status_o,
  output logic signed [VW-1:0] entry_value_o,
  output logic [CW-1:0]        entry_count_o,
  output logic                 last_o
);

  logic     push, pop, q_full, q_empty;
  pol_cmd_t front_cmd, queue_cmd;

  assign busy = q_full;

  pol_front u_front (
    .start_i    (start),
    .full_i     (q_full),
    .mode_i     (mode_i),
    .value_i    (value_i),
    .position_i (position_i),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  pol_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .cmd_o   (queue_cmd)
  );

  pol_back #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .valid_o       (valid_o),
    .status_o      (status_o),
    .entry_value_o (entry_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

endmodule
